[src/itrt_pkg.sv]
// itrt_pkg: shared types, constants and helpers for integer_to_radix_text.
// Used by itrt_ctrl, itrt_datapath and the top level. No dependencies.
package itrt_pkg;

    localparam int DATA_W          = 32;
    localparam int RADIX_W         = 5;
    localparam int CHAR_W          = 7;
    localparam int DIGIT_W         = 4;
    localparam int MAX_DIGITS      = 32;
    localparam int NDIG_W          = 6;
    localparam int LEN_W           = 7;
    localparam int STEPS_PER_CYCLE = 8;
    localparam int DIV_CYCLES      = DATA_W / STEPS_PER_CYCLE;
    localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);
    localparam int MAX_CHARS_DEF   = 33;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_F     = 7'h46;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [RADIX_W-1:0]       radix;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic prep;
        logic shift;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic last_char;
    } dp_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

[src/integer_to_radix_text.sv]
// integer_to_radix_text: signed 32-bit integer to ASCII text in base 2..16.
// Each digit is made by a run of divider steps at 8 quotient bits each and a check,
//   after the input transfer; then one character per cycle while not stalled.
// A new number is taken only once the last character of the previous one is sent.
// Reset: asynchronous active-low rst_n returns the controller to idle.
// Depends on itrt_pkg, itrt_ctrl, itrt_datapath.
module integer_to_radix_text #(
    parameter int MAX_CHARS = itrt_pkg::MAX_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  itrt_pkg::in_item_t  num,
    output logic                txt_valid,
    input  logic                txt_stall,
    output itrt_pkg::out_item_t txt
);

    itrt_pkg::dp_cmd_t  cmd;
    itrt_pkg::dp_stat_t stat;

    itrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    itrt_datapath #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .num   (num),
        .stat  (stat),
        .txt   (txt)
    );

    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid |-> num_stall)
        else $error("input taken while characters pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (num_valid && !num_stall) |=> (num_stall && !txt_valid))
        else $error("not converting after input transfer");

    a_last_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
        (txt_valid && !txt_stall && txt.last) |=> !txt_valid)
        else $error("characters after last");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid |-> ((txt.character == itrt_pkg::ASCII_MINUS)
                       || ((txt.character >= itrt_pkg::ASCII_ZERO)
                           && (txt.character <= itrt_pkg::ASCII_NINE))
                       || ((txt.character >= itrt_pkg::ASCII_A)
                           && (txt.character <= itrt_pkg::ASCII_F))))
        else $error("illegal character");

endmodule

[src/itrt_datapath.sv]
// itrt_datapath: magnitude, 8-bit-per-cycle radix divider, digit stack and
// character output for integer_to_radix_text. Depends on itrt_pkg.
module itrt_datapath #(
    parameter int MAX_CHARS = itrt_pkg::MAX_CHARS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itrt_pkg::dp_cmd_t    cmd,
    input  itrt_pkg::in_item_t   num,
    output itrt_pkg::dp_stat_t   stat,
    output itrt_pkg::out_item_t  txt
);

    localparam int CW    = $clog2(MAX_CHARS + 1);
    localparam int BUF_W = itrt_pkg::MAX_DIGITS * itrt_pkg::DIGIT_W;

    logic [itrt_pkg::DATA_W-1:0]  mag_reg, mag_next;
    logic [itrt_pkg::DIGIT_W-1:0] rmd_reg, rmd_next;
    logic [itrt_pkg::RADIX_W-1:0] base_reg, base_next;
    logic                         neg_reg, neg_next;
    logic                         sign_pend_reg, sign_pend_next;
    logic [BUF_W-1:0]             dig_reg, dig_next;
    logic [itrt_pkg::NDIG_W-1:0]  ndig_reg, ndig_next;
    logic [CW-1:0]                rem_reg, rem_next;

    logic [itrt_pkg::DATA_W-1:0]  q_step;
    logic [itrt_pkg::DIGIT_W-1:0] r_step;
    logic [itrt_pkg::RADIX_W-1:0] base_clamp;
    logic [itrt_pkg::LEN_W-1:0]   len;
    logic [itrt_pkg::LEN_W-1:0]   max_len;
    logic [itrt_pkg::LEN_W-1:0]   total;

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        logic [itrt_pkg::RADIX_W-1:0] t;
        q_step = mag_reg;
        r_step = rmd_reg;
        for (int i = 0; i < itrt_pkg::STEPS_PER_CYCLE; i++)
        begin
            t = {r_step, q_step[itrt_pkg::DATA_W-1]};
            if (t >= base_reg)
            begin
                r_step = itrt_pkg::DIGIT_W'(t - base_reg);
                q_step = {q_step[itrt_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_step = t[itrt_pkg::DIGIT_W-1:0];
                q_step = {q_step[itrt_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (num.radix < itrt_pkg::RADIX_MIN)
        begin
            base_clamp = itrt_pkg::RADIX_MIN;
        end
        else if (num.radix > itrt_pkg::RADIX_MAX)
        begin
            base_clamp = itrt_pkg::RADIX_MAX;
        end
        else
        begin
            base_clamp = num.radix;
        end
    end

    assign len     = itrt_pkg::LEN_W'(neg_reg) + itrt_pkg::LEN_W'(ndig_reg);
    assign max_len = itrt_pkg::LEN_W'(MAX_CHARS);
    assign total   = (len < max_len) ? len : max_len;

    always_comb
    begin
        mag_next       = mag_reg;
        rmd_next       = rmd_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        dig_next       = dig_reg;
        ndig_next      = ndig_reg;
        rem_next       = rem_reg;
        if (cmd.load)
        begin
            neg_next  = num.value[itrt_pkg::DATA_W-1];
            mag_next  = num.value[itrt_pkg::DATA_W-1]
                        ? (itrt_pkg::DATA_W'(0) - itrt_pkg::DATA_W'(num.value))
                        : itrt_pkg::DATA_W'(num.value);
            base_next = base_clamp;
            rmd_next  = '0;
            ndig_next = '0;
        end
        if (cmd.step)
        begin
            mag_next = q_step;
            rmd_next = r_step;
        end
        if (cmd.finish)
        begin
            mag_next  = q_step;
            rmd_next  = '0;
            dig_next  = {r_step, dig_reg[BUF_W-1:itrt_pkg::DIGIT_W]};
            ndig_next = ndig_reg + 1'b1;
        end
        if (cmd.prep)
        begin
            rem_next       = CW'(total);
            sign_pend_next = neg_reg;
        end
        if (cmd.shift)
        begin
            rem_next = rem_reg - 1'b1;
            if (sign_pend_reg)
            begin
                sign_pend_next = 1'b0;
            end
            else
            begin
                dig_next = {dig_reg[BUF_W-itrt_pkg::DIGIT_W-1:0], itrt_pkg::DIGIT_W'(0)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            rmd_reg       <= '0;
            base_reg      <= itrt_pkg::RADIX_MIN;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            dig_reg       <= '0;
            ndig_reg      <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            mag_reg       <= mag_next;
            rmd_reg       <= rmd_next;
            base_reg      <= base_next;
            neg_reg       <= neg_next;
            sign_pend_reg <= sign_pend_next;
            dig_reg       <= dig_next;
            ndig_reg      <= ndig_next;
            rem_reg       <= rem_next;
        end
    end

    assign stat.conv_done = (mag_reg == '0)
                            || (ndig_reg == itrt_pkg::NDIG_W'(itrt_pkg::MAX_DIGITS));
    assign stat.last_char = (rem_reg == CW'(1));

    assign txt.character = sign_pend_reg
                           ? itrt_pkg::ASCII_MINUS
                           : itrt_pkg::digit_to_ascii(
                                 dig_reg[BUF_W-1:BUF_W-itrt_pkg::DIGIT_W]);
    assign txt.last      = stat.last_char;

endmodule

[src/itrt_ctrl.sv]
// itrt_ctrl: sequencing state machine for integer_to_radix_text.
// Drives datapath commands and both handshakes. Depends on itrt_pkg.
module itrt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               num_valid,
    output logic               num_stall,
    output logic               txt_valid,
    input  logic               txt_stall,
    input  itrt_pkg::dp_stat_t stat,
    output itrt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CHECK, ST_EMIT} state_t;

    state_t                         state_reg, state_next;
    logic [itrt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           last_div;

    assign last_div = (cnt_reg == itrt_pkg::DIV_CNT_W'(itrt_pkg::DIV_CYCLES - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_div)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_CHECK:
            begin
                cnt_next = '0;
                if (stat.conv_done)
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_EMIT:
            begin
                if (!txt_stall)
                begin
                    cmd.shift = 1'b1;
                    if (stat.last_char)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign num_stall = (state_reg != ST_IDLE);
    assign txt_valid = (state_reg == ST_EMIT);

endmodule
